### rtl/iole_pkg.sv
// ----------------------------------------------------------------------------
// iole_pkg
// Opcodes, status codes and word widths shared by the indexed ordered list
// engine.
// ----------------------------------------------------------------------------
package iole_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned ValW    = 32;
  localparam int unsigned PosW    = 5;
  localparam int unsigned StW     = 2;
  localparam int unsigned FposW   = 4;
  localparam int unsigned CntW    = 5;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  localparam logic [OpW-1:0] OP_APPEND = 3'd0;
  localparam logic [OpW-1:0] OP_INSERT = 3'd1;
  localparam logic [OpW-1:0] OP_REMOVE = 3'd2;
  localparam logic [OpW-1:0] OP_FIND   = 3'd3;
  localparam logic [OpW-1:0] OP_GET    = 3'd4;

  localparam logic [StW-1:0] ST_OK       = 2'd0;
  localparam logic [StW-1:0] ST_RANGE    = 2'd1;
  localparam logic [StW-1:0] ST_FULL     = 2'd2;
  localparam logic [StW-1:0] ST_NOTFOUND = 2'd3;

endpackage

### rtl/indexed_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list_engine
// Ordered list of signed 32-bit values in an array with one read and one write
// port, with append, insert, remove, find and get driven by a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word fields (lowest bit first)
//  s_axis   in         opcode[2:0], value[34:3], position[39:35]
//  m_axis   out        status[1:0], read_value[33:2], found_position[37:34],
//                      count[42:38], zero fill[47:43]
//
//  Find, insert and remove walk the array one entry per cycle through the
//  single memory read port, so their length grows with the entry count.
//  Reset clears state, count, pend and valid; unwritten entries go unused.
//  A finished word waits in the output register while the next item is taken;
//  the sequencer stalls only if it finishes before that word is taken.
//
module indexed_ordered_list_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // opcode, value, position
  input  logic [iole_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // status, read_value, found_position, count, zero fill
  output logic [iole_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned PW  = (CW > iole_pkg::PosW) ? CW : iole_pkg::PosW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_TAIL  = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_FIND  = 3'd4;
  localparam logic [2:0] S_GET   = 3'd5;
  localparam logic [2:0] S_GETW  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]                  state_q, state_d;
  logic [CW-1:0]               count_q, count_d;
  logic [iole_pkg::OpW-1:0]    op_q, op_d;
  logic signed [31:0]          val_q, val_d;
  logic [AW-1:0]               put_q, put_d;
  logic [CW-1:0]               ptr_q, ptr_d;
  logic [CW-1:0]               last_q, last_d;
  logic [AW-1:0]               cmp_q, cmp_d;
  logic [AW-1:0]               wa_q, wa_d;
  logic                        pend_q, pend_d;
  logic [iole_pkg::StW-1:0]    st_q, st_d;
  logic signed [31:0]          rd_q, rd_d;
  logic [iole_pkg::FposW-1:0]  fpos_q, fpos_d;

  logic                        ovalid_q, ovalid_d;
  logic [iole_pkg::OutDataW-1:0] odata_q, odata_d;

  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [AW-1:0]               mem_ra;
  logic signed [31:0]          mem_wd;
  logic signed [31:0]          mem [CAPACITY];
  logic signed [31:0]          rdata_q;

  logic [iole_pkg::OpW-1:0]    in_op;
  logic signed [31:0]          in_val;
  logic [iole_pkg::PosW-1:0]   in_pos;
  logic [PW-1:0]               pos_x;
  logic [PW-1:0]               cnt_x;
  logic                        full;
  logic                        accept;
  logic [CW-1:0]               new_count;

  assign in_op  = s_axis_tdata_i[2:0];
  assign in_val = s_axis_tdata_i[34:3];
  assign in_pos = s_axis_tdata_i[39:35];
  assign pos_x  = PW'(in_pos);
  assign cnt_x  = PW'(count_q);
  assign full   = (count_q == CW'(CAPACITY));

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  always_comb begin
    new_count = count_q;
    if (st_q == iole_pkg::ST_OK) begin
      if (op_q == iole_pkg::OP_APPEND || op_q == iole_pkg::OP_INSERT) begin
        new_count = count_q + CW'(1);
      end else if (op_q == iole_pkg::OP_REMOVE) begin
        new_count = count_q - CW'(1);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    op_d     = op_q;
    val_d    = val_q;
    put_d    = put_q;
    ptr_d    = ptr_q;
    last_d   = last_q;
    cmp_d    = cmp_q;
    wa_d     = wa_q;
    pend_d   = pend_q;
    st_d     = st_q;
    rd_d     = rd_q;
    fpos_d   = fpos_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    mem_we   = 1'b0;
    mem_wa   = wa_q;
    mem_wd   = rdata_q;
    mem_ra   = put_q;

    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = in_op;
          val_d  = in_val;
          st_d   = iole_pkg::ST_OK;
          rd_d   = '0;
          fpos_d = '0;
          pend_d = 1'b0;
          put_d  = AW'(in_pos);
          state_d = S_DONE;
          case (in_op)
            iole_pkg::OP_APPEND: begin
              if (full) begin
                st_d = iole_pkg::ST_FULL;
              end else begin
                put_d   = AW'(count_q);
                state_d = S_PUT;
              end
            end
            iole_pkg::OP_INSERT: begin
              if (pos_x > cnt_x) begin
                st_d = iole_pkg::ST_RANGE;
              end else if (full) begin
                st_d = iole_pkg::ST_FULL;
              end else if (pos_x == cnt_x) begin
                state_d = S_PUT;
              end else begin
                ptr_d   = count_q - CW'(1);
                last_d  = CW'(in_pos);
                state_d = S_SHIFT;
              end
            end
            iole_pkg::OP_REMOVE: begin
              if (pos_x >= cnt_x) begin
                st_d = iole_pkg::ST_RANGE;
              end else if (pos_x != cnt_x - PW'(1)) begin
                ptr_d   = CW'(in_pos) + CW'(1);
                last_d  = count_q - CW'(1);
                state_d = S_SHIFT;
              end
            end
            iole_pkg::OP_FIND: begin
              if (count_q == '0) begin
                st_d = iole_pkg::ST_NOTFOUND;
              end else begin
                ptr_d   = '0;
                state_d = S_FIND;
              end
            end
            iole_pkg::OP_GET: begin
              if (pos_x >= cnt_x) begin
                st_d = iole_pkg::ST_RANGE;
              end else begin
                state_d = S_GET;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SHIFT: begin
        mem_ra = ptr_q[AW-1:0];
        mem_we = pend_q;
        pend_d = 1'b1;
        if (op_q == iole_pkg::OP_INSERT) begin
          wa_d = ptr_q[AW-1:0] + AW'(1);
        end else begin
          wa_d = ptr_q[AW-1:0] - AW'(1);
        end
        if (ptr_q == last_q) begin
          state_d = S_TAIL;
        end else if (op_q == iole_pkg::OP_INSERT) begin
          ptr_d = ptr_q - CW'(1);
        end else begin
          ptr_d = ptr_q + CW'(1);
        end
      end
      S_TAIL: begin
        mem_we = 1'b1;
        pend_d = 1'b0;
        state_d = (op_q == iole_pkg::OP_INSERT) ? S_PUT : S_DONE;
      end
      S_PUT: begin
        mem_we  = 1'b1;
        mem_wa  = put_q;
        mem_wd  = val_q;
        state_d = S_DONE;
      end
      S_FIND: begin
        mem_ra = ptr_q[AW-1:0];
        if (pend_q && rdata_q == val_q) begin
          fpos_d  = iole_pkg::FposW'(cmp_q);
          pend_d  = 1'b0;
          state_d = S_DONE;
        end else if (ptr_q == count_q) begin
          st_d    = iole_pkg::ST_NOTFOUND;
          pend_d  = 1'b0;
          state_d = S_DONE;
        end else begin
          cmp_d  = ptr_q[AW-1:0];
          ptr_d  = ptr_q + CW'(1);
          pend_d = 1'b1;
        end
      end
      S_GET: begin
        state_d = S_GETW;
      end
      S_GETW: begin
        rd_d    = rdata_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          odata_d  = {5'd0, iole_pkg::CntW'(new_count), fpos_q, rd_q, st_q};
          count_d  = new_count;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    val_q   <= val_d;
    put_q   <= put_d;
    ptr_q   <= ptr_d;
    last_q  <= last_d;
    cmp_q   <= cmp_d;
    wa_q    <= wa_d;
    st_q    <= st_d;
    rd_q    <= rd_d;
    fpos_q  <= fpos_d;
    odata_q <= odata_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CW'(mem_wa) < count_q + CW'(1)) && (CW'(mem_wa) < CW'(CAPACITY)))
    else $error("array write outside the occupied range");

  a_find_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND) |-> (ptr_q <= count_q))
    else $error("find pointer ran past the entry count");

  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted word did not start the sequencer");

  a_count_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == S_DONE))
    else $error("entry count changed outside the result step");
`endif

endmodule
